@@ src/sspl_pkg.sv @@
// Package for the symmetric sparse pattern lookup block.
// Holds the payload structs, request codes, queue sizing and back-end states.
// No dependencies.
`timescale 1ns / 1ps

package sspl_pkg;

    // Fixed widths of the payload fields.
    localparam int COORD_W = 16;
    localparam int VALUE_W = 32;

    // Default sizing handed to the top-level parameters.
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_INDEX_BITS  = 16;

    // Command queue between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register map.
    localparam int     PADDR_W   = 3;
    localparam logic   REG_SCALE = 1'b0;
    localparam logic [VALUE_W-1:0] SCALE_RESET = 32'h0001_0000;

    // Request codes.
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] row_index;
        logic [COORD_W-1:0] col_index;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic                      hit;
        logic                      table_full;
    } t_out_item;

    // Classified command: coordinates already masked, lookups already swapped.
    typedef struct packed {
        logic               is_lookup;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_COMPARE
    } t_bk_state;

endpackage

@@ src/sspl_front.sv @@
// Front end: accepts input beats, masks coordinates and folds lookups to row >= col.
// Depends on sspl_pkg.
`timescale 1ns / 1ps

module sspl_front
    import sspl_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    localparam int CW = (INDEX_BITS < COORD_W) ? INDEX_BITS : COORD_W;

    logic               r_valid;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic [COORD_W-1:0] row_m;
    logic [COORD_W-1:0] col_m;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        row_m           = COORD_W'(i_in_item.row_index[CW-1:0]);
        col_m           = COORD_W'(i_in_item.col_index[CW-1:0]);
        n_cmd.is_lookup = (i_in_item.req_type == REQ_LOOKUP);
        n_cmd.row       = row_m;
        n_cmd.col       = col_m;
        // Lookups search the lower triangle only.
        if (n_cmd.is_lookup && (row_m < col_m)) begin
            n_cmd.row = col_m;
            n_cmd.col = row_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ src/sspl_queue.sv @@
// Short command queue that decouples the front end from the search engine.
// Depends on sspl_pkg.
`timescale 1ns / 1ps

module sspl_queue
    import sspl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_buf[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (push) begin
            r_buf[r_wptr] <= i_push_cmd;
        end
    end

endmodule

@@ src/sspl_back.sv @@
// Back end: coordinate table memory, append logic and the binary search engine.
// Depends on sspl_pkg.
`timescale 1ns / 1ps

module sspl_back
    import sspl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    input  logic [VALUE_W-1:0] i_scale,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item
);

    localparam int CW    = (INDEX_BITS < COORD_W) ? INDEX_BITS : COORD_W;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_bk_state        r_state;
    t_bk_state        n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] n_lo;
    logic [CNT_W-1:0] r_hi;
    logic [CNT_W-1:0] n_hi;
    logic [CNT_W-1:0] r_mid;
    logic [CNT_W-1:0] n_mid;
    logic [CW-1:0]    r_key_row;
    logic [CW-1:0]    n_key_row;
    logic [CW-1:0]    r_key_col;
    logic [CW-1:0]    n_key_col;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic [2*CW-1:0]  r_mem [TABLE_DEPTH];
    logic [2*CW-1:0]  r_rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [2*CW-1:0]  wr_data;
    logic [AW-1:0]    rd_addr;

    logic             take;
    logic             table_is_full;
    logic [CW-1:0]    e_row;
    logic [CW-1:0]    e_col;
    logic             go_low;
    logic             found;

    assign o_cmd_ready   = (r_state == BK_IDLE) && !r_out_valid;
    assign take          = i_cmd_valid && o_cmd_ready;
    assign table_is_full = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out_item;

    assign e_row  = r_rd_data[2*CW-1:CW];
    assign e_col  = r_rd_data[CW-1:0];
    assign found  = (e_row == r_key_row) && (e_col == r_key_col);
    assign go_low = (e_row > r_key_row) || ((e_row == r_key_row) && (e_col > r_key_col));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (take && i_cmd.is_lookup) begin
                    n_state = BK_ISSUE;
                end
            end
            BK_ISSUE: begin
                if (r_lo >= r_hi) begin
                    n_state = BK_IDLE;
                end else begin
                    n_state = BK_COMPARE;
                end
            end
            BK_COMPARE: begin
                if (found) begin
                    n_state = BK_IDLE;
                end else begin
                    n_state = BK_ISSUE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath and result.
    always_comb begin
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key_row   = r_key_row;
        n_key_col   = r_key_col;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = {i_cmd.row[CW-1:0], i_cmd.col[CW-1:0]};
        rd_addr     = r_mid[AW-1:0];
        unique case (r_state)
            BK_IDLE: begin
                if (take) begin
                    if (i_cmd.is_lookup) begin
                        n_key_row = i_cmd.row[CW-1:0];
                        n_key_col = i_cmd.col[CW-1:0];
                        n_lo      = '0;
                        n_hi      = r_count;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{value_out: '0, hit: 1'b0,
                                        table_full: table_is_full};
                        if (!table_is_full) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            BK_ISSUE: begin
                n_mid   = r_lo + ((r_hi - r_lo) >> 1);
                rd_addr = n_mid[AW-1:0];
                // An empty interval means the key is not in the table.
                if (r_lo >= r_hi) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{value_out: '0, hit: 1'b0, table_full: 1'b0};
                end
            end
            BK_COMPARE: begin
                if (found) begin
                    n_out_valid = 1'b1;
                    n_out_item  = '{value_out: i_scale, hit: 1'b1, table_full: 1'b0};
                end else if (go_low) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + CNT_W'(1);
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_key_row  <= n_key_row;
        r_key_col  <= n_key_col;
        r_out_item <= n_out_item;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

@@ src/symmetric_sparse_pattern_lookup_core.sv @@
// Top level of the symmetric sparse pattern lookup block.
// Depends on sspl_pkg, sspl_front, sspl_queue and sspl_back.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_item) takes one request per beat:
//   an append stores (row, col) at the next free table slot (a full table stores nothing
//   and flags table_full), a lookup folds the coordinate to row >= col and binary-searches
//   the stored list. The output channel (o_out_valid / i_out_ready / o_out_item) returns
//   exactly one result beat per request, in request order.
//   The APB port holds scale_value at byte address 0; pready is always high.
// Request path:
//   A request passes a front register and a two-entry queue before the search engine.
//   An append writes the table and its result register when taken. A lookup alternates
//   issue and compare states per search step, with one registered read of the single
//   table read port per step, and ends on a hit or an empty interval. The engine takes
//   no new request until the previous result has left the output register.
// Reset:
//   Synchronous, active low. The table is emptied (entry count zero) and the
//   scale returns to 1.0; table contents are not cleared.
// Stalls:
//   A result waits in the output register while i_out_ready is low; the queue
//   keeps accepting requests until it and the front register are full.
`timescale 1ns / 1ps

module symmetric_sparse_pattern_lookup_core
    import sspl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [VALUE_W-1:0] pwdata,
    output logic [VALUE_W-1:0] prdata,
    output logic               pready
);

    logic               scale_sel;
    logic [VALUE_W-1:0] r_scale_value;
    logic               fr_valid;
    logic               fr_ready;
    t_cmd               fr_cmd;
    logic               q_valid;
    logic               q_ready;
    t_cmd               q_cmd;

    assign pready    = 1'b1;
    assign scale_sel = (paddr[PADDR_W-1] == REG_SCALE);
    assign prdata    = scale_sel ? r_scale_value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_value <= SCALE_RESET;
        end else if (psel && penable && pwrite && pready && scale_sel) begin
            r_scale_value <= pwdata;
        end
    end

    sspl_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_cmd_valid(fr_valid),
        .i_cmd_ready(fr_ready),
        .o_cmd      (fr_cmd)
    );

    sspl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(fr_valid),
        .o_push_ready(fr_ready),
        .i_push_cmd  (fr_cmd),
        .o_pop_valid (q_valid),
        .i_pop_ready (q_ready),
        .o_pop_cmd   (q_cmd)
    );

    sspl_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(q_valid),
        .o_cmd_ready(q_ready),
        .i_cmd      (q_cmd),
        .i_scale    (r_scale_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule
